// ===== rtl/segf_pkg.sv =====
// Shared types, constants and helper functions for the segment follow block.
// Used by segf_ctrl, segf_dp, the top level and the checker. No dependencies.
package segf_pkg;

  localparam int COORD_W           = 24;
  localparam int LEN_W             = 23;
  localparam int CORDIC_ITERATIONS = 20;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
  localparam int SQRT_STEPS        = 32;
  localparam int DIVF_STEPS        = 24;
  localparam int CNT_W             = 5;

  localparam logic [LEN_W-1:0] LEN_RESET = 23'd25600;
  localparam logic [30:0]      GAIN_Q31  = 31'd1304065748;

  // binary angle = (r * 2^32 + 11520) / 23040 = (r * 2^23 + 22) / 45
  //              = r * 186413 + (23 * r + 22) / 45
  localparam logic [31:0] BANG_BASE  = 32'd186413;
  localparam logic [31:0] BANG_REM   = 32'd23;
  localparam logic [31:0] BANG_RND   = 32'd22;
  // exact floor(n / 45) for n < 2^20
  localparam logic [20:0] RECIP45    = 21'd1491309;
  localparam int          RECIP45_SH = 26;

  localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(SQRT_STEPS - 1);
  localparam logic [CNT_W-1:0] DIVF_LAST   = CNT_W'(DIVF_STEPS - 1);
  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_NORM, ST_SQY, ST_SQADD, ST_SQRT,
    ST_MULX, ST_DINX, ST_DIVX, ST_OFFX, ST_MULY, ST_DINY, ST_DIVY, ST_OFFY,
    ST_DINA, ST_DIVA, ST_ANGMUL, ST_ANGX, ST_CORDIC, ST_ROT, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_NORM, OP_SQX, OP_SQY, OP_SQADD, OP_SQRT,
    OP_MULX, OP_MULY, OP_DINX, OP_DINY, OP_DIV, OP_OFFX, OP_OFFY,
    OP_DINA, OP_DIVA, OP_ANGMUL, OP_ANGX, OP_CORDIC, OP_ROT, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic degen;
    logic norm_done;
    logic out_free;
  } status_t;

  function automatic logic [31:0] atan_q32(input logic [CNT_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [27:0] v);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    hi = 28'sd8388607;
    lo = -28'sd8388608;
    if (v > hi) return COORD_W'(hi);
    if (v < lo) return COORD_W'(lo);
    return v[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/segf_ctrl.sv =====
// Sequencer for the segment follow block: steps the datapath through each item.
// Depends on segf_pkg; drives segf_dp through cmd_t and reads status_t.
module segf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  segf_pkg::status_t st,
  output segf_pkg::cmd_t    cmd
);

  segf_pkg::state_t             state_r, state_nxt;
  logic [segf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  segf_pkg::dp_op_t             op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= segf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  function automatic logic loop_end(input logic [segf_pkg::CNT_W-1:0] c,
                                    input logic [segf_pkg::CNT_W-1:0] last);
    return c == last;
  endfunction

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      segf_pkg::ST_IDLE:   if (in_valid) state_nxt = segf_pkg::ST_CHECK;
      segf_pkg::ST_CHECK: begin
        if (st.func)       state_nxt = segf_pkg::ST_DINA;
        else if (st.degen) state_nxt = segf_pkg::ST_FIN;
        else               state_nxt = segf_pkg::ST_NORM;
      end
      segf_pkg::ST_NORM:   if (st.norm_done) state_nxt = segf_pkg::ST_SQY;
      segf_pkg::ST_SQY:    state_nxt = segf_pkg::ST_SQADD;
      segf_pkg::ST_SQADD:  state_nxt = segf_pkg::ST_SQRT;
      segf_pkg::ST_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (loop_end(cnt_r, segf_pkg::SQRT_LAST)) begin
          cnt_nxt = '0; state_nxt = segf_pkg::ST_MULX;
        end
      end
      segf_pkg::ST_MULX:   state_nxt = segf_pkg::ST_DINX;
      segf_pkg::ST_DINX:   state_nxt = segf_pkg::ST_DIVX;
      segf_pkg::ST_DIVX: begin
        cnt_nxt = cnt_r + 1'b1;
        if (loop_end(cnt_r, segf_pkg::DIVF_LAST)) begin
          cnt_nxt = '0; state_nxt = segf_pkg::ST_OFFX;
        end
      end
      segf_pkg::ST_OFFX:   state_nxt = segf_pkg::ST_MULY;
      segf_pkg::ST_MULY:   state_nxt = segf_pkg::ST_DINY;
      segf_pkg::ST_DINY:   state_nxt = segf_pkg::ST_DIVY;
      segf_pkg::ST_DIVY: begin
        cnt_nxt = cnt_r + 1'b1;
        if (loop_end(cnt_r, segf_pkg::DIVF_LAST)) begin
          cnt_nxt = '0; state_nxt = segf_pkg::ST_OFFY;
        end
      end
      segf_pkg::ST_OFFY:   state_nxt = segf_pkg::ST_FIN;
      segf_pkg::ST_DINA:   state_nxt = segf_pkg::ST_DIVA;
      segf_pkg::ST_DIVA:   state_nxt = segf_pkg::ST_ANGMUL;
      segf_pkg::ST_ANGMUL: state_nxt = segf_pkg::ST_ANGX;
      segf_pkg::ST_ANGX:   state_nxt = segf_pkg::ST_CORDIC;
      segf_pkg::ST_CORDIC: begin
        cnt_nxt = cnt_r + 1'b1;
        if (loop_end(cnt_r, segf_pkg::CORDIC_LAST)) begin
          cnt_nxt = '0; state_nxt = segf_pkg::ST_ROT;
        end
      end
      segf_pkg::ST_ROT:    state_nxt = segf_pkg::ST_FIN;
      segf_pkg::ST_FIN:    if (st.out_free) state_nxt = segf_pkg::ST_IDLE;
      default:             state_nxt = segf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op = segf_pkg::OP_NONE;
    case (state_r)
      segf_pkg::ST_IDLE:   if (in_valid) op = segf_pkg::OP_LOAD;
      segf_pkg::ST_NORM:   op = st.norm_done ? segf_pkg::OP_SQX : segf_pkg::OP_NORM;
      segf_pkg::ST_SQY:    op = segf_pkg::OP_SQY;
      segf_pkg::ST_SQADD:  op = segf_pkg::OP_SQADD;
      segf_pkg::ST_SQRT:   op = segf_pkg::OP_SQRT;
      segf_pkg::ST_MULX:   op = segf_pkg::OP_MULX;
      segf_pkg::ST_DINX:   op = segf_pkg::OP_DINX;
      segf_pkg::ST_DIVX:   op = segf_pkg::OP_DIV;
      segf_pkg::ST_OFFX:   op = segf_pkg::OP_OFFX;
      segf_pkg::ST_MULY:   op = segf_pkg::OP_MULY;
      segf_pkg::ST_DINY:   op = segf_pkg::OP_DINY;
      segf_pkg::ST_DIVY:   op = segf_pkg::OP_DIV;
      segf_pkg::ST_OFFY:   op = segf_pkg::OP_OFFY;
      segf_pkg::ST_DINA:   op = segf_pkg::OP_DINA;
      segf_pkg::ST_DIVA:   op = segf_pkg::OP_DIVA;
      segf_pkg::ST_ANGMUL: op = segf_pkg::OP_ANGMUL;
      segf_pkg::ST_ANGX:   op = segf_pkg::OP_ANGX;
      segf_pkg::ST_CORDIC: op = segf_pkg::OP_CORDIC;
      segf_pkg::ST_ROT:    op = segf_pkg::OP_ROT;
      segf_pkg::ST_FIN:    if (st.out_free) op = segf_pkg::OP_OUT;
      default:             op = segf_pkg::OP_NONE;
    endcase
  end

  assign in_stall = (state_r != segf_pkg::ST_IDLE);
  assign cmd.op   = op;
  assign cmd.cnt  = cnt_r;

endmodule

// ===== rtl/segf_dp.sv =====
// Datapath: segment endpoints, length register, shared multiplier, square root,
// restoring divider and CORDIC. Depends on segf_pkg; commanded by segf_ctrl.
module segf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  segf_pkg::cmd_t                      cmd,
  output segf_pkg::status_t                   st,
  input  logic                                cfg_we,
  input  logic [segf_pkg::LEN_W-1:0]          cfg_data,
  input  logic                                in_func,
  input  logic signed [segf_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [segf_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [15:0]                  in_angle_deg,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [segf_pkg::COORD_W-1:0] out_tail_x,
  output logic signed [segf_pkg::COORD_W-1:0] out_tail_y,
  output logic signed [segf_pkg::COORD_W-1:0] out_tip_x,
  output logic signed [segf_pkg::COORD_W-1:0] out_tip_y,
  output logic                                out_degenerate
);

  localparam int CW = segf_pkg::COORD_W;

  logic [segf_pkg::LEN_W-1:0] len_r;
  logic out_valid_r, degen_r, func_r, out_degen_r;
  logic signed [CW-1:0] tail_x_r, tail_y_r, tip_x_r, tip_y_r;
  logic signed [CW-1:0] tx_r, ty_r, ntail_x_r, ntail_y_r, ntip_x_r, ntip_y_r;
  logic signed [15:0] ang_r;
  logic negx_r, negy_r;
  logic [30:0] ux_r, uy_r;
  logic [61:0] p_r;
  logic [63:0] n_r, res_r, bit_r;
  logic [31:0] dd_r, rem_r, lo_r, quo_r;
  logic signed [33:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [1:0] qd_r;

  // shared multiplier
  logic [30:0] ma, mb;
  logic [61:0] prod;
  always_comb begin
    ma = ux_r; mb = ux_r;
    case (cmd.op)
      segf_pkg::OP_SQY:    begin ma = uy_r; mb = uy_r; end
      segf_pkg::OP_MULX:   begin ma = 31'(len_r); mb = ux_r; end
      segf_pkg::OP_MULY:   begin ma = 31'(len_r); mb = uy_r; end
      segf_pkg::OP_ANGMUL: begin ma = 31'(len_r); mb = segf_pkg::GAIN_Q31; end
      default:             begin ma = ux_r; mb = ux_r; end
    endcase
  end
  assign prod = ma * mb;

  logic signed [24:0] dx, dy;
  assign dx = 25'(in_target_x) - 25'(tail_x_r);
  assign dy = 25'(in_target_y) - 25'(tail_y_r);

  logic [63:0] sq_trial;
  assign sq_trial = res_r + bit_r;

  logic [54:0] dnum;
  assign dnum = 55'(p_r) + 55'(res_r[31:1]);

  logic [32:0] dtrial;
  logic        dge;
  assign dtrial = {rem_r, lo_r[31]};
  assign dge    = dtrial >= {1'b0, dd_r};

  logic signed [17:0] a18, r18;
  always_comb begin
    a18 = 18'(ang_r);
    if (a18 >= 18'sd23040)  r18 = a18 - 18'sd23040;
    else if (a18 + 18'sd23040 < 0) r18 = a18 + 18'sd46080;
    else if (a18 < 0)       r18 = a18 + 18'sd23040;
    else                    r18 = a18;
  end

  logic [40:0] recip;
  assign recip = 41'(lo_r[19:0]) * 41'(segf_pkg::RECIP45);

  logic signed [33:0] xs, ys;
  logic [31:0] atv;
  assign xs  = x_r >>> cmd.cnt;
  assign ys  = y_r >>> cmd.cnt;
  assign atv = segf_pkg::atan_q32(cmd.cnt);

  logic signed [24:0] offx, offy;
  assign offx = negx_r ? -$signed({1'b0, quo_r[23:0]}) : $signed({1'b0, quo_r[23:0]});
  assign offy = negy_r ? -$signed({1'b0, quo_r[23:0]}) : $signed({1'b0, quo_r[23:0]});

  logic signed [33:0] xr, yr, xrr, yrr;
  always_comb begin
    case (qd_r)
      2'd1:    begin xr = -y_r; yr = x_r;  end
      2'd2:    begin xr = -x_r; yr = -y_r; end
      2'd3:    begin xr = y_r;  yr = -x_r; end
      default: begin xr = x_r;  yr = y_r;  end
    endcase
    xrr = (xr + 34'sd128) >>> 8;
    yrr = (yr + 34'sd128) >>> 8;
  end

  logic [29:0] bres;
  assign bres = quo_r[29:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= segf_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
      out_degen_r <= 1'b0;
      tail_x_r    <= '0;
      tail_y_r    <= '0;
      tip_x_r     <= '0;
      tip_y_r     <= '0;
      degen_r     <= 1'b0;
      func_r      <= 1'b0;
    end else begin
      if (cfg_we) len_r <= cfg_data;
      if (cmd.op == segf_pkg::OP_OUT) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (cmd.op)
        segf_pkg::OP_LOAD: begin
          func_r    <= in_func;
          degen_r   <= !in_func && (dx == 0) && (dy == 0);
          tx_r      <= in_target_x;
          ty_r      <= in_target_y;
          ang_r     <= in_angle_deg;
          negx_r    <= dx < 0;
          negy_r    <= dy < 0;
          ux_r      <= 31'(dx < 0 ? 25'(-dx) : 25'(dx));
          uy_r      <= 31'(dy < 0 ? 25'(-dy) : 25'(dy));
          ntail_x_r <= tail_x_r;
          ntail_y_r <= tail_y_r;
          ntip_x_r  <= in_func ? tip_x_r : in_target_x;
          ntip_y_r  <= in_func ? tip_y_r : in_target_y;
        end
        segf_pkg::OP_NORM: begin
          ux_r <= {ux_r[29:0], 1'b0};
          uy_r <= {uy_r[29:0], 1'b0};
        end
        segf_pkg::OP_SQX:  p_r <= prod;
        segf_pkg::OP_SQY: begin
          n_r <= 64'(p_r);
          p_r <= prod;
        end
        segf_pkg::OP_SQADD: begin
          n_r   <= n_r + 64'(p_r);
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
        segf_pkg::OP_SQRT: begin
          if (n_r >= sq_trial) begin
            n_r   <= n_r - sq_trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        segf_pkg::OP_MULX, segf_pkg::OP_MULY: p_r <= prod;
        segf_pkg::OP_DINX, segf_pkg::OP_DINY: begin
          dd_r  <= res_r[31:0];
          rem_r <= {1'b0, dnum[54:24]};
          lo_r  <= {dnum[23:0], 8'd0};
          quo_r <= '0;
        end
        segf_pkg::OP_DINA: begin
          quo_r <= 32'(r18[14:0]) * segf_pkg::BANG_BASE;
          lo_r  <= 32'(r18[14:0]) * segf_pkg::BANG_REM + segf_pkg::BANG_RND;
        end
        segf_pkg::OP_DIVA: quo_r <= quo_r + 32'(recip >> segf_pkg::RECIP45_SH);
        segf_pkg::OP_DIV: begin
          rem_r <= dge ? 32'(dtrial - {1'b0, dd_r}) : dtrial[31:0];
          lo_r  <= {lo_r[30:0], 1'b0};
          quo_r <= {quo_r[30:0], dge};
        end
        segf_pkg::OP_OFFX: ntail_x_r <= segf_pkg::sat_coord(28'(tx_r) - 28'(offx));
        segf_pkg::OP_OFFY: ntail_y_r <= segf_pkg::sat_coord(28'(ty_r) - 28'(offy));
        segf_pkg::OP_ANGMUL: begin
          p_r <= prod;
          if (bres[29]) begin
            z_r  <= {2'b11, bres};
            qd_r <= quo_r[31:30] + 2'd1;
          end else begin
            z_r  <= {2'b00, bres};
            qd_r <= quo_r[31:30];
          end
        end
        segf_pkg::OP_ANGX: begin
          x_r <= $signed(34'((p_r + 62'd4194304) >> 23));
          y_r <= '0;
        end
        segf_pkg::OP_CORDIC: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - $signed(atv);
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + $signed(atv);
          end
        end
        segf_pkg::OP_ROT: begin
          ntip_x_r <= segf_pkg::sat_coord(28'(tail_x_r) + 28'(xrr));
          ntip_y_r <= segf_pkg::sat_coord(28'(tail_y_r) + 28'(yrr));
        end
        segf_pkg::OP_OUT: begin
          tail_x_r    <= ntail_x_r;
          tail_y_r    <= ntail_y_r;
          tip_x_r     <= ntip_x_r;
          tip_y_r     <= ntip_y_r;
          out_degen_r <= degen_r;
        end
        default: ;
      endcase
    end
  end

  assign st.func      = func_r;
  assign st.degen     = degen_r;
  assign st.norm_done = ux_r[30] | uy_r[30];
  assign st.out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_tail_x     = tail_x_r;
  assign out_tail_y     = tail_y_r;
  assign out_tip_x      = tip_x_r;
  assign out_tip_y      = tip_y_r;
  assign out_degenerate = out_degen_r;

endmodule

// ===== rtl/ik_segment_follow.sv =====
// One rigid segment (tail, tip) in signed Q16.8 that follows a target or is set by angle.
// Top level; depends on segf_pkg, segf_ctrl and segf_dp.
//
// One item at a time; in_stall is low only while the block is idle. A follow item
// first normalizes with 7 to 30 single-bit shifts, then runs 32 square root steps
// on a 64-bit remainder, then two 24-step restoring divisions through the one shared
// divider. A degenerate follow (target on the tail) skips all of these. A set-angle
// item runs a reciprocal multiply to a binary angle, then one CORDIC step per cycle
// for 20 iterations. The result is held on the out_ ports until taken; an item whose
// result is ready waits for the previous one to be taken, and no next item is taken
// while it waits. segment_length is written through cfg_.
module ik_segment_follow (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [segf_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [segf_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [15:0]                  in_angle_deg,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [segf_pkg::COORD_W-1:0] out_tail_x,
  output logic signed [segf_pkg::COORD_W-1:0] out_tail_y,
  output logic signed [segf_pkg::COORD_W-1:0] out_tip_x,
  output logic signed [segf_pkg::COORD_W-1:0] out_tip_y,
  output logic                                out_degenerate,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [segf_pkg::LEN_W-1:0]          cfg_data
);

  segf_pkg::cmd_t    cmd;
  segf_pkg::status_t st;

  assign cfg_ready = 1'b1;

  segf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  segf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .in_func        (in_func),
    .in_target_x    (in_target_x),
    .in_target_y    (in_target_y),
    .in_angle_deg   (in_angle_deg),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_tail_x     (out_tail_x),
    .out_tail_y     (out_tail_y),
    .out_tip_x      (out_tip_x),
    .out_tip_y      (out_tip_y),
    .out_degenerate (out_degenerate)
  );

endmodule

// ===== rtl/segf_checker.sv =====
// Port-level checks for ik_segment_follow, attached by the bind below.
// Depends on segf_pkg for port widths.
module segf_props (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [segf_pkg::COORD_W-1:0] out_tail_x,
  input logic signed [segf_pkg::COORD_W-1:0] out_tip_x,
  input logic                                out_degenerate
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_tail_x) && $stable(out_tip_x)
      && $stable(out_degenerate))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken before the first finished");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind ik_segment_follow segf_props u_segf_props (.*);
